// File: design/ibs_pkg.sv
package ibs_pkg;

	// input beat: one pixel write or one sample request
	typedef struct packed {
		logic               mode;
		logic [8:0]         write_col;
		logic [8:0]         write_row;
		logic [31:0]        pixel_word;
		logic signed [23:0] sample_u;
		logic signed [23:0] sample_v;
	} req_t;

	// output beat: one sample result
	typedef struct packed {
		logic               inside_res;
		logic [7:0]         channel_0;
		logic [7:0]         channel_1;
		logic [7:0]         channel_2;
		logic signed [31:0] scalar_value;
	} rsp_t;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [1:0] FMT_RGB8 = 2'd0;
	localparam logic [1:0] FMT_U16  = 2'd1;
	localparam logic [1:0] FMT_S32  = 2'd2;

	localparam logic [1:0] REG_COLS   = 2'd0;
	localparam logic [1:0] REG_ROWS   = 2'd1;
	localparam logic [1:0] REG_FORMAT = 2'd2;

	// widest store address and fraction the parameters allow
	localparam int ADDR_W_MAX = 24;
	localparam int FRAC_W_MAX = 16;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_SAMPLE,
		CMD_OUTSIDE
	} cmd_kind_t;

	// classified command from front to back
	typedef struct packed {
		cmd_kind_t               kind;
		logic [ADDR_W_MAX-1:0]   addr;
		logic [31:0]             wdata;
		logic [FRAC_W_MAX-1:0]   dx;
		logic [FRAC_W_MAX-1:0]   dy;
	} cmd_t;

	// back end status seen by the top level
	typedef struct packed {
		logic [2:0] pend;
		logic [1:0] step;
	} back_stat_t;

endpackage

// File: design/ibs_ram.sv
module ibs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: design/ibs_fifo.sv
module ibs_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// File: design/ibs_front.sv
module ibs_front #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ibs_pkg::req_t req,
	input  logic [9:0]    image_cols,
	input  logic [9:0]    image_rows,
	output logic          cmd_valid,
	input  logic          cmd_pop,
	output ibs_pkg::cmd_t cmd
);

	localparam int AW = $clog2(MAX_COLS * MAX_ROWS);
	localparam int IW = 24 - FRAC_BITS;
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLS);

	logic          full;
	logic          empty;
	logic          push;
	logic [IW-1:0] x;
	logic [IW-1:0] y;
	logic          outside;
	logic          write_ok;
	logic [AW-1:0] sample_addr;
	logic [AW-1:0] write_addr;
	ibs_pkg::cmd_t cmd_in;

	// floor the coordinates and test the top-left neighbour
	always_comb begin
		x = req.sample_u[23:FRAC_BITS];
		y = req.sample_v[23:FRAC_BITS];
		outside = req.sample_u[23] || req.sample_v[23]
			|| (24'(x) > 24'(image_cols) - 24'd2)
			|| (24'(y) > 24'(image_rows) - 24'd2);
		sample_addr = AW'(y) * ROW_STRIDE + AW'(x);
		write_ok = (32'(req.write_col) < MAX_COLS) && (32'(req.write_row) < MAX_ROWS);
		write_addr = AW'(req.write_row) * ROW_STRIDE + AW'(req.write_col);
	end

	// build the command
	always_comb begin
		cmd_in = '0;
		cmd_in.wdata = req.pixel_word;
		cmd_in.dx = ibs_pkg::FRAC_W_MAX'(req.sample_u[FRAC_BITS-1:0]);
		cmd_in.dy = ibs_pkg::FRAC_W_MAX'(req.sample_v[FRAC_BITS-1:0]);
		if (req.mode == ibs_pkg::MODE_WRITE) begin
			cmd_in.kind = ibs_pkg::CMD_WRITE;
			cmd_in.addr = ibs_pkg::ADDR_W_MAX'(write_addr);
		end else if (outside) begin
			cmd_in.kind = ibs_pkg::CMD_OUTSIDE;
			cmd_in.addr = '0;
		end else begin
			cmd_in.kind = ibs_pkg::CMD_SAMPLE;
			cmd_in.addr = ibs_pkg::ADDR_W_MAX'(sample_addr);
		end
	end

	// writes outside the store are dropped on accept
	assign req_ready = !full;
	assign push = req_valid && req_ready && (req.mode == ibs_pkg::MODE_SAMPLE || write_ok);
	assign cmd_valid = !empty;

	ibs_fifo #(
		.T     (ibs_pkg::cmd_t),
		.DEPTH (ibs_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd),
		.empty  (empty)
	);

endmodule

// File: design/ibs_back.sv
module ibs_back #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  ibs_pkg::cmd_t       cmd,
	output logic                cmd_pop,
	input  logic [1:0]          pixel_format,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ibs_pkg::rsp_t       rsp,
	output ibs_pkg::back_stat_t stat
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = FRAC_BITS + 1;
	localparam int WW = 2 * FRAC_BITS + 1;
	localparam int SH = 2 * FRAC_BITS;
	localparam int PCW = 8 + WW;
	localparam int PSW = 33 + WW + 1;
	localparam int ACW = PCW + 2;
	localparam int ASW = PSW + 2;
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLS);
	localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;
	localparam logic [SH-1:0] HALF = SH'(1) << (SH - 1);

	// issue side
	logic [1:0]           step_q;
	logic [1:0]           step_d;
	logic [2:0]           pend_q;
	logic                 slot_free;
	logic                 reserve;
	logic                 issue;
	logic                 rd;
	logic                 first;
	logic                 last;
	logic                 ram_we;
	logic [AW-1:0]        base;
	logic [AW-1:0]        ram_addr;
	logic [31:0]          ram_rdata;
	logic [SW-1:0]        wx;
	logic [SW-1:0]        wy;
	logic [WW-1:0]        wgt;

	// pipeline
	logic                 v_s1, rd_s1, first_s1, last_s1;
	logic [WW-1:0]        wgt_s1;
	logic                 v_s2, rd_s2, first_s2, last_s2;
	logic [PCW-1:0]       prod_ch_s2 [3];
	logic signed [PSW-1:0] prod_sc_s2;
	logic                 done_s3, in_s3;
	logic [ACW-1:0]       acc_ch_q [3];
	logic signed [ASW-1:0] acc_sc_q;
	logic signed [32:0]   pix_ext;

	// rounding
	logic [ACW-SH-1:0]    qc [3];
	logic                 incc [3];
	logic [ACW-SH-1:0]    qci [3];
	logic                 neg;
	logic [ASW-1:0]       mag;
	logic [ASW-SH-1:0]    qs;
	logic [ASW-SH-1:0]    qsi;
	logic [ASW-SH-1:0]    qsn;
	ibs_pkg::rsp_t        rnd;

	logic                 out_full;
	logic                 out_empty;
	logic                 out_pop;

	assign slot_free = pend_q < 3'(ibs_pkg::OUT_DEPTH);
	assign base = cmd.addr[AW-1:0];

	// sequencer: at most one store access per cycle; samples and outside results wait for a free result slot
	always_comb begin
		ram_we = 1'b0;
		issue = 1'b0;
		reserve = 1'b0;
		rd = 1'b0;
		first = 1'b0;
		last = 1'b0;
		cmd_pop = 1'b0;
		step_d = step_q;
		if (cmd_valid) begin
			unique case (cmd.kind)
				ibs_pkg::CMD_WRITE: begin
					ram_we = 1'b1;
					cmd_pop = 1'b1;
				end
				ibs_pkg::CMD_OUTSIDE: begin
					if (slot_free) begin
						reserve = 1'b1;
						issue = 1'b1;
						first = 1'b1;
						last = 1'b1;
						cmd_pop = 1'b1;
					end
				end
				ibs_pkg::CMD_SAMPLE: begin
					if (step_q != 2'd0 || slot_free) begin
						reserve = step_q == 2'd0;
						issue = 1'b1;
						rd = 1'b1;
						first = step_q == 2'd0;
						last = step_q == 2'd3;
						cmd_pop = step_q == 2'd3;
						step_d = step_q + 2'd1;
					end
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	// neighbour address and weight for this step
	always_comb begin
		case (step_q)
			2'd0: ram_addr = base;
			2'd1: ram_addr = base + AW'(1);
			2'd2: ram_addr = base + ROW_STRIDE;
			default: ram_addr = base + ROW_STRIDE + AW'(1);
		endcase
		if (ram_we) begin
			ram_addr = base;
		end
		wx = step_q[0] ? SW'(cmd.dx[FRAC_BITS-1:0]) : ONE - SW'(cmd.dx[FRAC_BITS-1:0]);
		wy = step_q[1] ? SW'(cmd.dy[FRAC_BITS-1:0]) : ONE - SW'(cmd.dy[FRAC_BITS-1:0]);
		wgt = WW'(wx * wy);
	end

	ibs_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (cmd.wdata),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			pend_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			step_q <= step_d;
			pend_q <= pend_q + 3'(reserve) - 3'(out_pop);
			v_s1 <= issue;
			v_s2 <= v_s1;
			done_s3 <= v_s2 && last_s2;
		end
	end

	// pixel widened as the format reads it
	always_comb begin
		if (pixel_format == ibs_pkg::FMT_U16) begin
			pix_ext = {17'b0, ram_rdata[15:0]};
		end else begin
			pix_ext = {ram_rdata[31], ram_rdata};
		end
	end

	// s1 tag, s2 products, s3 accumulate
	always_ff @(posedge clk) begin
		rd_s1 <= rd;
		first_s1 <= first;
		last_s1 <= last;
		wgt_s1 <= wgt;
		rd_s2 <= rd_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		for (int j = 0; j < 3; j++) begin
			prod_ch_s2[j] <= PCW'(ram_rdata[8*j +: 8] * wgt_s1);
		end
		prod_sc_s2 <= PSW'(pix_ext * $signed({1'b0, wgt_s1}));
		if (v_s2) begin
			in_s3 <= rd_s2;
			for (int j = 0; j < 3; j++) begin
				acc_ch_q[j] <= first_s2 ? ACW'(prod_ch_s2[j])
					: acc_ch_q[j] + ACW'(prod_ch_s2[j]);
			end
			acc_sc_q <= first_s2 ? ASW'(prod_sc_s2) : acc_sc_q + ASW'(prod_sc_s2);
		end
	end

	// rounding per format
	always_comb begin
		rnd = '0;
		for (int j = 0; j < 3; j++) begin
			qc[j] = acc_ch_q[j][ACW-1:SH];
			incc[j] = (acc_ch_q[j][SH-1:0] > HALF)
				|| (acc_ch_q[j][SH-1:0] == HALF && qc[j][0]);
			qci[j] = qc[j] + (ACW-SH)'(incc[j]);
		end
		neg = acc_sc_q[ASW-1];
		mag = neg ? ASW'(-acc_sc_q) : ASW'(acc_sc_q);
		qs = mag[ASW-1:SH];
		qsi = qs + (ASW-SH)'(mag[SH-1:0] >= HALF);
		qsn = neg ? -qsi : qsi;
		if (in_s3) begin
			rnd.inside_res = 1'b1;
			if (pixel_format == ibs_pkg::FMT_RGB8) begin
				rnd.channel_0 = (qci[0] > (ACW-SH)'(255)) ? 8'hFF : qci[0][7:0];
				rnd.channel_1 = (qci[1] > (ACW-SH)'(255)) ? 8'hFF : qci[1][7:0];
				rnd.channel_2 = (qci[2] > (ACW-SH)'(255)) ? 8'hFF : qci[2][7:0];
			end else if (pixel_format == ibs_pkg::FMT_U16) begin
				rnd.scalar_value = (qsi > (ASW-SH)'(65535)) ? 32'h0000FFFF
					: {16'b0, qsi[15:0]};
			end else begin
				rnd.scalar_value = qsn[31:0];
			end
		end
	end

	// result queue, slots reserved at issue so it never overflows
	assign out_pop = rsp_valid && rsp_ready;
	assign rsp_valid = !out_empty;

	ibs_fifo #(
		.T     (ibs_pkg::rsp_t),
		.DEPTH (ibs_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (done_s3 && !out_full),
		.din    (rnd),
		.full   (out_full),
		.pop    (out_pop),
		.dout   (rsp),
		.empty  (out_empty)
	);

	assign stat.pend = pend_q;
	assign stat.step = step_q;

endmodule

// File: design/bilinear_image_sampler_core.sv
// Bilinear image sampler.
// req channel (req_valid/req_ready/req): mode 0 writes pixel_word at
// (write_row, write_col); mode 1 samples at fixed-point (sample_u, sample_v).
// rsp channel (rsp_valid/rsp_ready/rsp): one beat per sample, none per write.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): image_cols, image_rows,
// pixel_format; always ready, write only while the block is idle.
// An inside sample reads its neighbours one after another from the single-port pixel
// store; a write uses one store access, an outside sample reads none, and a new sample waits for a free result slot.
// A sample's result passes through the command queue, the sequencer, the s1, s2
// and s3 registers and the result queue before rsp_valid shows it.
// Reset clears all control state and sets the registers to their reset
// values; the pixel store is not cleared and must be written before it is read.
// When rsp_ready is held low, up to four results wait in the result queue and
// the command queue absorbs further beats; then req_ready drops.
module bilinear_image_sampler_core #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ibs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ibs_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam logic [9:0] COLS_RST = (MAX_COLS > 512) ? 10'd512 : 10'(MAX_COLS);
	localparam logic [9:0] ROWS_RST = (MAX_ROWS > 512) ? 10'd512 : 10'(MAX_ROWS);

	logic [9:0]          cols_q;
	logic [9:0]          rows_q;
	logic [1:0]          fmt_q;
	logic [9:0]          size_v;
	logic [9:0]          cols_d;
	logic [9:0]          rows_d;
	logic                cmd_valid;
	logic                cmd_pop;
	ibs_pkg::cmd_t       cmd;
	ibs_pkg::back_stat_t stat;

	assign cfg_ready = 1'b1;

	// saturate sizes to the store
	always_comb begin
		size_v = cfg_data[9:0];
		cols_d = (size_v < 10'd2) ? 10'd2
			: ((32'(size_v) > MAX_COLS) ? 10'(MAX_COLS) : size_v);
		rows_d = (size_v < 10'd2) ? 10'd2
			: ((32'(size_v) > MAX_ROWS) ? 10'(MAX_ROWS) : size_v);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
			fmt_q <= ibs_pkg::FMT_RGB8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ibs_pkg::REG_COLS: cols_q <= cols_d;
				ibs_pkg::REG_ROWS: rows_q <= rows_d;
				ibs_pkg::REG_FORMAT: fmt_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	ibs_front #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.image_cols (cols_q),
		.image_rows (rows_q),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	ibs_back #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.pixel_format (fmt_q),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.stat         (stat)
	);

	// reserved result slots never exceed the queue
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pend <= 3'(ibs_pkg::OUT_DEPTH))
		else $error("result reservations exceed queue depth");

	// a waiting result always holds a reservation
	a_rsp_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> stat.pend != 3'd0)
		else $error("result beat without reservation");

	// a started sample reads its neighbours on consecutive cycles
	a_step_runs: assert property (@(posedge clk) disable iff (!arst_n)
		stat.step != 2'd0 |=> stat.step == $past(stat.step) + 2'd1)
		else $error("neighbour read sequence stalled");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int STORE_COLS = 512;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BEATS = 180;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	ibs_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	ibs_pkg::rsp_t rsp;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [31:0]   cfg_data;

	bilinear_image_sampler_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// image state and register copy used for prediction
	logic [31:0] image_px [int];
	bit          staged_px [int];
	int unsigned img_cols;
	int unsigned img_rows;
	logic [1:0]  img_fmt;

	ibs_pkg::req_t pending_beats [$];
	ibs_pkg::rsp_t expected_samples [$];

	bit          failed;
	bit          no_idle;
	bit          req_fire;
	int          hold_token;
	int          hold_seen;
	int          hold_left;
	longint      cycles;
	int unsigned queued_beats;
	int unsigned phase_start;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input logic [31:0] d);
		int unsigned v;
		v = d[9:0];
		if (v < 2) return 2;
		if (v > 512) return 512;
		return v;
	endfunction

	function automatic longint unsigned round_sum(input longint unsigned mag, input bit even);
		longint unsigned q;
		longint unsigned r;
		q = mag >> 16;
		r = mag & 64'hFFFF;
		if (r > 64'h8000 || (r == 64'h8000 && (!even || q[0])))
			q++;
		return q;
	endfunction

	function automatic longint weigh(input longint a, input longint b, input longint c,
			input longint d, input longint fx, input longint fy);
		return a * (256 - fx) * (256 - fy) + b * fx * (256 - fy) +
			c * (256 - fx) * fy + d * fx * fy;
	endfunction

	function automatic logic [31:0] px_at(input int col, input int row);
		int a;
		a = row * STORE_COLS + col;
		return image_px.exists(a) ? image_px[a] : 32'h0;
	endfunction

	// bilinear result for one sample beat
	function automatic ibs_pkg::rsp_t interp_sample(input ibs_pkg::req_t r);
		ibs_pkg::rsp_t o;
		int x, y;
		longint fx, fy, acc;
		logic [31:0] p [4];
		longint unsigned q, mag;
		bit neg;
		o = '0;
		if (r.sample_u < 0 || r.sample_v < 0) return o;
		x = r.sample_u[23:8];
		y = r.sample_v[23:8];
		fx = r.sample_u[7:0];
		fy = r.sample_v[7:0];
		if (x > int'(img_cols) - 2 || y > int'(img_rows) - 2) return o;
		p[0] = px_at(x, y);
		p[1] = px_at(x + 1, y);
		p[2] = px_at(x, y + 1);
		p[3] = px_at(x + 1, y + 1);
		o.inside_res = 1'b1;
		if (img_fmt == ibs_pkg::FMT_RGB8) begin
			for (int c = 0; c < 3; c++) begin
				acc = weigh(p[0][8*c +: 8], p[1][8*c +: 8], p[2][8*c +: 8],
					p[3][8*c +: 8], fx, fy);
				q = round_sum(acc, 1'b1);
				if (q > 255) q = 255;
				if (c == 0) o.channel_0 = q[7:0];
				else if (c == 1) o.channel_1 = q[7:0];
				else o.channel_2 = q[7:0];
			end
		end else if (img_fmt == ibs_pkg::FMT_U16) begin
			acc = weigh(p[0][15:0], p[1][15:0], p[2][15:0], p[3][15:0], fx, fy);
			q = round_sum(acc, 1'b0);
			if (q > 64'hFFFF) q = 64'hFFFF;
			o.scalar_value = q[31:0];
		end else begin
			acc = weigh(longint'($signed(p[0])), longint'($signed(p[1])),
				longint'($signed(p[2])), longint'($signed(p[3])), fx, fy);
			neg = acc < 0;
			mag = neg ? -acc : acc;
			q = round_sum(mag, 1'b0);
			if (neg) q = -q;
			o.scalar_value = q[31:0];
		end
		return o;
	endfunction

	// accepted beats: update the image or queue the expected sample
	always @(posedge clk) begin
		req_fire = req_valid && req_ready;
		if (req_fire) begin
			if (req.mode == ibs_pkg::MODE_WRITE)
				image_px[req.write_row * STORE_COLS + req.write_col] = req.pixel_word;
			else
				expected_samples.insert(expected_samples.size(), interp_sample(req));
		end
	end

	// result checker
	always @(posedge clk) begin
		ibs_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_samples.size() == 0) begin
				$error("unexpected result beat %p", rsp);
				failed = 1'b1;
			end else begin
				e = expected_samples.pop_front();
				if (rsp.inside_res !== e.inside_res) begin
					$error("inside_res exp %0d got %0d", e.inside_res, rsp.inside_res);
					failed = 1'b1;
				end
				if (rsp.channel_0 !== e.channel_0) begin
					$error("channel_0 exp %0d got %0d", e.channel_0, rsp.channel_0);
					failed = 1'b1;
				end
				if (rsp.channel_1 !== e.channel_1) begin
					$error("channel_1 exp %0d got %0d", e.channel_1, rsp.channel_1);
					failed = 1'b1;
				end
				if (rsp.channel_2 !== e.channel_2) begin
					$error("channel_2 exp %0d got %0d", e.channel_2, rsp.channel_2);
					failed = 1'b1;
				end
				if (rsp.scalar_value !== e.scalar_value) begin
					$error("scalar_value exp %0d got %0d", e.scalar_value, rsp.scalar_value);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fire)) begin
			if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
				req <= pending_beats.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= no_idle || $urandom_range(99) >= 28;
			end
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == ibs_pkg::REG_COLS) img_cols = clamp_dim(d);
		else if (idx == ibs_pkg::REG_ROWS) img_rows = clamp_dim(d);
		else img_fmt = d[1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || req_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_pixel();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_dim();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd2;
			3: return 32'd512;
			4: return 32'd1023;
			5: return {22'($urandom_range(32'h3FFFFF)), 10'd3};
			6: return $urandom;
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	task automatic put_pixel(input int col, input int row, input logic [31:0] d);
		ibs_pkg::req_t r;
		r = '0;
		r.mode = ibs_pkg::MODE_WRITE;
		r.write_col = 9'(col);
		r.write_row = 9'(row);
		r.pixel_word = d;
		r.sample_u = 24'($urandom);
		r.sample_v = 24'($urandom);
		pending_beats.insert(pending_beats.size(), r);
		staged_px[row * STORE_COLS + col] = 1'b1;
		queued_beats++;
	endtask

	// queue a sample, first writing any neighbour of an inside sample that was never written
	task automatic put_sample(input logic [23:0] u, input logic [23:0] v);
		ibs_pkg::req_t r;
		int x, y;
		if (!u[23] && !v[23]) begin
			x = u[23:8];
			y = v[23:8];
			if (x <= int'(img_cols) - 2 && y <= int'(img_rows) - 2)
				for (int k = 0; k < 4; k++)
					if (!staged_px.exists((y + k / 2) * STORE_COLS + x + k % 2))
						put_pixel(x + k % 2, y + k / 2, rand_pixel());
		end
		r = '0;
		r.mode = ibs_pkg::MODE_SAMPLE;
		r.write_col = 9'($urandom);
		r.write_row = 9'($urandom);
		r.pixel_word = $urandom;
		r.sample_u = u;
		r.sample_v = v;
		pending_beats.insert(pending_beats.size(), r);
		queued_beats++;
	endtask

	function automatic logic [7:0] rand_frac();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd128;
			2: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_beat();
		int r;
		logic [14:0] x, y;
		r = $urandom_range(99);
		if (r < 10) begin
			put_pixel($urandom_range(511), $urandom_range(511), rand_pixel());
		end else if (r < 72) begin
			x = 15'($urandom_range(img_cols - 2));
			y = 15'($urandom_range(img_rows - 2));
			put_sample({1'b0, x, rand_frac()}, {1'b0, y, rand_frac()});
		end else if (r < 88) begin
			x = 15'($urandom_range(img_cols - 2));
			y = 15'($urandom_range(img_rows - 2));
			if ($urandom_range(1)) x = 15'(img_cols - 1 + $urandom_range(2));
			else y = 15'(img_rows - 1 + $urandom_range(2));
			put_sample({1'b0, x, rand_frac()}, {1'b0, y, rand_frac()});
		end else begin
			put_sample(24'($urandom), 24'($urandom));
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ibs_pkg::REG_COLS;
		cfg_data = '0;
		failed = 1'b0;
		no_idle = 1'b0;
		req_fire = 1'b0;
		hold_token = 0;
		hold_seen = 0;
		hold_left = 0;
		cycles = 0;
		queued_beats = 0;
		phase_start = 0;
		img_cols = 512;
		img_rows = 512;
		img_fmt = ibs_pkg::FMT_RGB8;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, half-way rounding, image edge, sign extremes
		put_pixel(0, 0, 32'h0002_0102);
		put_pixel(1, 0, 32'h0003_0203);
		put_pixel(0, 1, 32'hFFFF_FFFF);
		put_pixel(1, 1, 32'h8000_0000);
		put_sample(24'h000000, 24'h000000);
		put_sample(24'h000080, 24'h000000);
		put_sample(24'h0000FF, 24'h0000FF);
		put_sample(24'h000080, 24'h000080);
		put_sample(24'hFFFF80, 24'h000000);
		put_sample(24'h800000, 24'h7FFFFF);
		put_sample({1'b0, 15'd510, 8'hFF}, {1'b0, 15'd510, 8'h01});
		put_sample({1'b0, 15'd511, 8'h00}, 24'h000000);
		put_sample(24'h000000, {1'b0, 15'd511, 8'h00});
		drain();
		cfg_write(ibs_pkg::REG_FORMAT, {30'd0, ibs_pkg::FMT_U16});
		put_sample(24'h000080, 24'h000000);
		put_sample(24'h000040, 24'h0000C0);
		put_sample(24'h0000FF, 24'h0000FF);
		drain();
		cfg_write(ibs_pkg::REG_FORMAT, {30'd0, ibs_pkg::FMT_S32});
		put_sample(24'h000000, 24'h000080);
		put_sample(24'h000080, 24'h000080);
		put_sample(24'h000001, 24'h0000FF);
		drain();
		cfg_write(ibs_pkg::REG_FORMAT, 32'hFFFF_FFFF);
		put_sample(24'h000033, 24'h0000A7);
		drain();

		// random phases over several image sizes and formats
		for (int ph = 0; ph < 9; ph++) begin
			cfg_write(ibs_pkg::REG_COLS, rand_dim());
			cfg_write(ibs_pkg::REG_ROWS, rand_dim());
			cfg_write(ibs_pkg::REG_FORMAT, $urandom);
			no_idle = (ph == 4);
			if (ph == 2) hold_token++;
			phase_start = queued_beats;
			while (queued_beats - phase_start < PHASE_BEATS) random_beat();
			drain();
		end
		no_idle = 1'b0;
		repeat (30) @(posedge clk);

		if (!failed) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
